[rtl/mkrm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkrm_pkg: shared types, constants and keyword table
// Transfer structs, mode and status codes, and the fixed keyword rows used by
// the response matcher.
// ----------------------------------------------------------------------------
package mkrm_pkg;

	localparam int NUM_KEYWORDS_DEF = 7;
	localparam int KEYWORD_LEN_DEF  = 20;
	localparam int POS_W            = 5;
	localparam int SHOWN_FLAGS      = 7;
	localparam int STATUS_KEYWORDS  = 4;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] CR_CHAR      = 8'h0D;
	localparam logic [7:0] NUL_CHAR     = 8'h00;

	localparam logic MODE_BYTE  = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	localparam logic [2:0] STATUS_NONE  = 3'd0;
	localparam logic [2:0] STATUS_OK    = 3'd1;
	localparam logic [2:0] STATUS_ERROR = 3'd2;
	localparam logic [2:0] STATUS_BUSY  = 3'd3;
	localparam logic [2:0] STATUS_FAIL  = 3'd4;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_char;
	} item_t;

	typedef struct packed {
		logic [SHOWN_FLAGS-1:0] found_flags;
		logic [2:0]             response_status;
	} result_t;

	// Character of a keyword row; NUL past the text or past the row length.
	function automatic logic [7:0] kw_char(input logic [3:0] row, input logic [POS_W-1:0] col,
			input logic [POS_W:0] klen);
		logic [95:0] txt;
		logic [3:0]  len;
		int          idx;
		txt = '0;
		len = '0;
		case (row)
			4'd0: begin
				txt = 96'({"OK", CR_CHAR, NEWLINE_CHAR});
				len = 4'd4;
			end
			4'd1: begin
				txt = 96'({"ERROR", CR_CHAR, NEWLINE_CHAR});
				len = 4'd7;
			end
			4'd2: begin
				txt = 96'({"BUSY", CR_CHAR, NEWLINE_CHAR});
				len = 4'd6;
			end
			4'd3: begin
				txt = 96'({"FAIL", CR_CHAR, NEWLINE_CHAR});
				len = 4'd6;
			end
			4'd4: begin
				txt = 96'({"CONNECTED", CR_CHAR, NEWLINE_CHAR});
				len = 4'd11;
			end
			4'd5: begin
				txt = 96'({"DISCONNECT", CR_CHAR, NEWLINE_CHAR});
				len = 4'd12;
			end
			4'd6: begin
				txt = 96'({"OK", CR_CHAR, NEWLINE_CHAR, "> "});
				len = 4'd6;
			end
			default: begin
				txt = '0;
				len = '0;
			end
		endcase
		if ({1'b0, col} < {2'b0, len} && {1'b0, col} < klen) begin
			idx = int'(len) - 1 - int'(col);
			return txt[8*idx +: 8];
		end
		return NUL_CHAR;
	endfunction

endpackage
`default_nettype wire

[rtl/mkrm_match.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkrm_match: keyword position and flag state with single-pass update
// Compares one byte against every keyword row in parallel, masks later rows
// behind the first that fires, and forms the flags and response status.
// ----------------------------------------------------------------------------
module mkrm_match #(
	parameter int NUM_KEYWORDS = mkrm_pkg::NUM_KEYWORDS_DEF,
	parameter int KEYWORD_LEN  = mkrm_pkg::KEYWORD_LEN_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire mkrm_pkg::item_t item,
	output mkrm_pkg::result_t    result
);

	logic [mkrm_pkg::POS_W-1:0] pos_q [NUM_KEYWORDS];
	logic [mkrm_pkg::POS_W-1:0] pos_d [NUM_KEYWORDS];
	logic [NUM_KEYWORDS-1:0]    flag_q;
	logic [NUM_KEYWORDS-1:0]    flag_d;
	logic [NUM_KEYWORDS-1:0]    hit;
	logic [NUM_KEYWORDS-1:0]    match;
	logic [NUM_KEYWORDS-1:0]    blocked;
	logic [mkrm_pkg::POS_W-1:0] adv [NUM_KEYWORDS];

	localparam logic [mkrm_pkg::POS_W:0] KLEN = (mkrm_pkg::POS_W+1)'(KEYWORD_LEN);

	always_comb begin
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			match[k] = item.rx_char == mkrm_pkg::kw_char(4'(k), pos_q[k], KLEN);
			if ({1'b0, pos_q[k]} + 1'b1 < KLEN) begin
				adv[k] = pos_q[k] + 1'b1;
			end else begin
				adv[k] = pos_q[k];
			end
			hit[k] = match[k] &&
				mkrm_pkg::kw_char(4'(k), adv[k], KLEN) == mkrm_pkg::NEWLINE_CHAR;
		end
	end

	// Prefix mask: the first firing row stops the rows after it.
	always_comb begin
		blocked[0] = 1'b0;
		for (int k = 1; k < NUM_KEYWORDS; k++) begin
			blocked[k] = blocked[k-1] | hit[k-1];
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			pos_d[k]  = pos_q[k];
			flag_d[k] = flag_q[k];
			if (item.mode == mkrm_pkg::MODE_CLEAR) begin
				flag_d[k] = 1'b0;
			end else if (!blocked[k]) begin
				pos_d[k]  = match[k] ? adv[k] : '0;
				flag_d[k] = flag_q[k] | hit[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYWORDS; k++) begin
				pos_q[k] <= '0;
			end
			flag_q <= '0;
		end else if (step) begin
			for (int k = 0; k < NUM_KEYWORDS; k++) begin
				pos_q[k] <= pos_d[k];
			end
			flag_q <= flag_d;
		end
	end

	always_comb begin
		result.found_flags = '0;
		for (int k = 0; k < mkrm_pkg::SHOWN_FLAGS; k++) begin
			if (k < NUM_KEYWORDS) begin
				result.found_flags[k] = flag_d[k];
			end
		end
		if (result.found_flags[0] && NUM_KEYWORDS > 0) begin
			result.response_status = mkrm_pkg::STATUS_OK;
		end else if (result.found_flags[1] && NUM_KEYWORDS > 1) begin
			result.response_status = mkrm_pkg::STATUS_ERROR;
		end else if (result.found_flags[2] && NUM_KEYWORDS > 2) begin
			result.response_status = mkrm_pkg::STATUS_BUSY;
		end else if (result.found_flags[3] && NUM_KEYWORDS > 3) begin
			result.response_status = mkrm_pkg::STATUS_FAIL;
		end else begin
			result.response_status = mkrm_pkg::STATUS_NONE;
		end
	end

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.mode == mkrm_pkg::MODE_CLEAR |=> flag_q == '0)
		else $error("flags survive a clear");

	a_one_new_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(flag_d & ~flag_q) <= 1)
		else $error("more than one keyword fired on one byte");

	a_status_has_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result.response_status != mkrm_pkg::STATUS_NONE |-> result.found_flags != '0)
		else $error("status without a found flag");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> flag_q == $past(flag_q))
		else $error("flags moved without a step");

endmodule
`default_nettype wire

[rtl/multi_keyword_response_matcher.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_keyword_response_matcher: modem reply keyword watcher
// Tracks seven reply keywords in a received byte stream and reports sticky
// found flags with a prioritised response status for every transfer.
//
//   channel  direction  handshake                   payload
//   item     in         item_valid / item_stall     mode, rx_char
//   result   out        result_valid / result_stall found_flags, response_status
//
// One transfer in per cycle while item_stall is low, one result per item,
// through an input register, then a result register behind the keyword compare.
// The rate is set by the combinational parallel compare of all keyword rows.
// Reset clears positions, flags and both valid registers at once.
// A stalled result holds; the input register keeps taking transfers while
// the result register is free or being drained.
// ----------------------------------------------------------------------------
module multi_keyword_response_matcher #(
	parameter int NUM_KEYWORDS = mkrm_pkg::NUM_KEYWORDS_DEF,
	parameter int KEYWORD_LEN  = mkrm_pkg::KEYWORD_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire mkrm_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output mkrm_pkg::result_t      result
);

	mkrm_pkg::item_t   item_s1;
	logic              valid_s1;
	mkrm_pkg::result_t result_q;
	logic              result_valid_q;
	mkrm_pkg::result_t next_result;
	logic              advance;
	logic              accept;

	assign advance    = valid_s1 && !(result_valid_q && result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	mkrm_match #(
		.NUM_KEYWORDS(NUM_KEYWORDS),
		.KEYWORD_LEN (KEYWORD_LEN)
	) u_match (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.item  (item_s1),
		.result(next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid_q)
		else $error("input stalled with nothing held");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |=> valid_s1 && item_s1 == $past(item_s1))
		else $error("held input stage lost its transfer");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid_q)
		else $error("result register not loaded");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the modem reply keyword watcher
// Feeds directed reply lines, then random keyword lines, corrupted lines,
// NUL runs, noise and clears with random gaps on both channels. A scoreboard
// tracks the per-keyword match positions and sticky flags and checks every
// returned flag set and response status in order.
// ----------------------------------------------------------------------------
module tb;
	import mkrm_pkg::*;

	localparam int NUM_KW      = NUM_KEYWORDS_DEF;
	localparam int KW_LEN      = KEYWORD_LEN_DEF;
	localparam int ITEM_TARGET = 950;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 160;

	class reply_scoreboard;
		byte unsigned kw[NUM_KW][KW_LEN];
		logic [POS_W-1:0] match_pos[NUM_KW];
		bit seen[NUM_KW];
		result_t pending_replies[$];
		int mismatch_count;
		int checked;

		function new();
			string stems[NUM_KW];
			int r;
			int c;
			int n;
			stems = '{"OK", "ERROR", "BUSY", "FAIL", "CONNECTED", "DISCONNECT", "OK"};
			mismatch_count = 0;
			checked = 0;
			for (r = 0; r < NUM_KW; r++) begin
				match_pos[r] = '0;
				seen[r] = 1'b0;
				for (c = 0; c < KW_LEN; c++)
					kw[r][c] = NUL_CHAR;
				n = stems[r].len();
				for (c = 0; c < n && c < KW_LEN; c++)
					kw[r][c] = stems[r][c];
				if (n < KW_LEN)
					kw[r][n] = CR_CHAR;
				if (n + 1 < KW_LEN)
					kw[r][n + 1] = NEWLINE_CHAR;
				if (r == 6 && n + 3 < KW_LEN) begin
					kw[r][n + 2] = ">";
					kw[r][n + 3] = " ";
				end
			end
		endfunction

		task report(string msg);
			mismatch_count++;
			$display("MISMATCH: %s", msg);
		endtask

		function void note_transfer(item_t it);
			result_t r;
			logic [POS_W-1:0] p;
			int k;
			if (it.mode == MODE_CLEAR) begin
				for (k = 0; k < NUM_KW; k++)
					seen[k] = 1'b0;
			end else begin
				for (k = 0; k < NUM_KW; k++) begin
					p = match_pos[k];
					if (it.rx_char == kw[k][p]) begin
						if (p < KW_LEN - 1)
							p = p + 1'b1;
						match_pos[k] = p;
						if (kw[k][p] == NEWLINE_CHAR) begin
							seen[k] = 1'b1;
							break;
						end
					end else begin
						match_pos[k] = '0;
					end
				end
			end
			r.found_flags = '0;
			for (k = 0; k < NUM_KW && k < SHOWN_FLAGS; k++)
				r.found_flags[k] = seen[k];
			if (seen[0])
				r.response_status = STATUS_OK;
			else if (seen[1])
				r.response_status = STATUS_ERROR;
			else if (seen[2])
				r.response_status = STATUS_BUSY;
			else if (seen[3])
				r.response_status = STATUS_FAIL;
			else
				r.response_status = STATUS_NONE;
			pending_replies.push_back(r);
		endfunction

		task check_reply(result_t got);
			result_t want;
			checked++;
			if (pending_replies.size() == 0) begin
				report($sformatf("unexpected result flags=%b status=%0d",
					got.found_flags, got.response_status));
				return;
			end
			want = pending_replies.pop_front();
			if (got.found_flags !== want.found_flags)
				report($sformatf("result %0d found_flags %b, want %b",
					checked, got.found_flags, want.found_flags));
			if (got.response_status !== want.response_status)
				report($sformatf("result %0d response_status %0d, want %0d",
					checked, got.response_status, want.response_status));
		endtask

		function int pending();
			return pending_replies.size();
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	reply_scoreboard sb;
	int items_sent;
	int cycle_count;
	bit tx_burst;
	bit rx_burst;

	multi_keyword_response_matcher dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_item(input item_t it);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note_transfer(it);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		item_t it;
		it.mode = MODE_BYTE;
		it.rx_char = b;
		send_item(it);
	endtask

	task automatic send_clear(input logic [7:0] b);
		item_t it;
		it.mode = MODE_CLEAR;
		it.rx_char = b;
		send_item(it);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_line();
		byte unsigned txt[$];
		int choice;
		int k;
		int i;
		int cut;
		choice = $urandom_range(0, 11);
		k = $urandom_range(0, NUM_KW - 1);
		for (i = 0; i < KW_LEN && sb.kw[k][i] != NUL_CHAR; i++)
			txt.push_back(sb.kw[k][i]);
		cut = $urandom_range(0, txt.size() - 1);
		case (choice)
			0: send_clear(8'($urandom_range(0, 255)));
			1: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			2: begin
				txt[cut] = 8'($urandom_range(0, 255));
				for (i = 0; i < txt.size(); i++)
					send_byte(txt[i]);
			end
			3: begin
				for (i = 0; i < txt.size(); i++)
					send_byte(txt[i]);
				repeat ($urandom_range(14, 18)) send_byte(NUL_CHAR);
			end
			4: begin
				for (i = 0; i <= cut; i++)
					send_byte(txt[i]);
			end
			default: begin
				for (i = 0; i < txt.size(); i++)
					send_byte(txt[i]);
			end
		endcase
	endtask

	initial begin
		int n;
		bit held;
		held = 1'b0;
		rx_burst = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held && sb.checked >= 300) begin
				held = 1'b1;
				n = HOLD_CYCLES;
			end else begin
				n = rx_burst ? 0 : $urandom_range(0, 7);
			end
			if ($urandom_range(0, 49) == 0)
				rx_burst = !rx_burst;
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			sb.check_reply(result);
		end
	end

	initial begin
		sb = new();
		items_sent = 0;
		tx_burst = 1'b0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		result_stall <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_clear(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("BUSY");
		send_byte(CR_CHAR);
		send_text("FAIL");
		send_byte(CR_CHAR);
		send_text("OK");
		send_byte(CR_CHAR);
		send_byte(NEWLINE_CHAR);
		send_text("> ");
		send_clear(8'h00);
		send_text("ERROR");
		send_byte(CR_CHAR);

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				tx_burst = !tx_burst;
			send_line();
		end
		item_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
rtl/mkrm_pkg.sv
rtl/mkrm_match.sv
rtl/multi_keyword_response_matcher.sv
tb/sv/tb.sv
